### src/marker_header_deframer_assert.svh
`ifndef MARKER_HEADER_DEFRAMER_ASSERT_SVH
`define MARKER_HEADER_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define MHD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define MHD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mhd_pkg.sv
package mhd_pkg;

    localparam logic [7:0]  MARK_FIRST   = 8'hA5;
    localparam logic [7:0]  MARK_SECOND  = 8'h5A;
    localparam logic [15:0] HEADER_BYTES = 16'd8;
    localparam logic [2:0]  CSUM_POS     = 3'd7;
    localparam logic [2:0]  FIRST_POS    = 3'd2;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1500;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_MARK2,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_CSUM     = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_PAYLOAD,
        K_LAST,
        K_CSUM_DROP,
        K_OVERSIZE,
        K_EMPTY
    } kind_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] proto;
        kind_t       kind;
    } rec_t;

endpackage

### src/mhd_front.sv
module mhd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_take,
    input  logic [7:0]    in_byte,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    output logic          rec_we,
    output mhd_pkg::rec_t rec
);

    mhd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] proto_reg, proto_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] max_payload_reg;
    logic [15:0] payload_len;

    assign payload_len = size_reg - mhd_pkg::HEADER_BYTES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= mhd_pkg::PH_HUNT;
            count_reg       <= '0;
            xor_reg         <= '0;
            proto_reg       <= '0;
            size_reg        <= '0;
            remain_reg      <= '0;
            max_payload_reg <= mhd_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                xor_reg    <= xor_next;
                proto_reg  <= proto_next;
                size_reg   <= size_next;
                remain_reg <= remain_next;
            end
            if (cfg_we)
            begin
                max_payload_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        proto_next  = proto_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        rec_we      = 1'b0;
        rec.data    = in_byte;
        rec.proto   = proto_reg;
        rec.kind    = mhd_pkg::K_PAYLOAD;

        case (phase_reg)
            mhd_pkg::PH_HUNT:
            begin
                if (in_byte == mhd_pkg::MARK_FIRST)
                begin
                    phase_next = mhd_pkg::PH_MARK2;
                end
            end
            mhd_pkg::PH_MARK2:
            begin
                if (in_byte == mhd_pkg::MARK_SECOND)
                begin
                    phase_next = mhd_pkg::PH_HEADER;
                    count_next = mhd_pkg::FIRST_POS;
                    xor_next   = mhd_pkg::MARK_FIRST ^ mhd_pkg::MARK_SECOND;
                end
                else if (in_byte != mhd_pkg::MARK_FIRST)
                begin
                    phase_next = mhd_pkg::PH_HUNT;
                end
            end
            mhd_pkg::PH_HEADER:
            begin
                case (count_reg)
                    3'd2:    proto_next = {in_byte, proto_reg[7:0]};
                    3'd3:    proto_next = {proto_reg[15:8], in_byte};
                    3'd4:    size_next  = {in_byte, size_reg[7:0]};
                    3'd5:    size_next  = {size_reg[15:8], in_byte};
                    default: ;
                endcase
                if (count_reg != mhd_pkg::CSUM_POS)
                begin
                    xor_next   = xor_reg ^ in_byte;
                    count_next = count_reg + 3'd1;
                end
                else if (in_byte != xor_reg)
                begin
                    phase_next = mhd_pkg::PH_HUNT;
                    count_next = '0;
                    xor_next   = '0;
                    rec_we     = in_take;
                    rec.kind   = mhd_pkg::K_CSUM_DROP;
                end
                else if (size_reg <= mhd_pkg::HEADER_BYTES)
                begin
                    phase_next = mhd_pkg::PH_HUNT;
                    count_next = '0;
                    xor_next   = '0;
                    rec_we     = in_take;
                    rec.kind   = mhd_pkg::K_EMPTY;
                end
                else if (payload_len > max_payload_reg)
                begin
                    phase_next = mhd_pkg::PH_HUNT;
                    count_next = '0;
                    xor_next   = '0;
                    rec_we     = in_take;
                    rec.kind   = mhd_pkg::K_OVERSIZE;
                end
                else
                begin
                    phase_next  = mhd_pkg::PH_PAYLOAD;
                    count_next  = '0;
                    remain_next = payload_len;
                end
            end
            mhd_pkg::PH_PAYLOAD:
            begin
                rec_we = in_take;
                if (remain_reg <= 16'd1)
                begin
                    remain_next = '0;
                    phase_next  = mhd_pkg::PH_HUNT;
                    count_next  = '0;
                    xor_next    = '0;
                    rec.kind    = mhd_pkg::K_LAST;
                end
                else
                begin
                    remain_next = remain_reg - 16'd1;
                end
            end
            default:
            begin
                phase_next = mhd_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

### src/mhd_fifo.sv
`include "marker_header_deframer_assert.svh"

module mhd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mhd_pkg::rec_t wr_rec,
    output logic          full,
    input  logic          rd_en,
    output logic          avail,
    output mhd_pkg::rec_t rd_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mhd_pkg::rec_t  mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_wr, do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign avail  = (count_reg != '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && avail;
    assign rd_rec = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MHD_ASSERT_IMP(a_no_overflow, 1'b1, count_reg <= CW'(DEPTH), "fifo count beyond depth")
    `MHD_ASSERT_IMP(a_no_drop, wr_en, !full, "word written into full fifo")
    `MHD_ASSERT_NXT(a_count_up, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1,
        "fifo count did not advance on write")

endmodule

### src/mhd_back.sv
module mhd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_avail,
    input  mhd_pkg::rec_t q_rec,
    output logic          q_rd,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    payload_byte,
    output logic [15:0]   protocol_id,
    output logic          last,
    output logic [1:0]    status
);

    logic            valid_reg;
    logic [7:0]      byte_reg;
    logic [15:0]     proto_reg;
    logic            last_reg;
    mhd_pkg::status_t status_reg;
    mhd_pkg::status_t st_next;
    logic            last_next;
    logic [7:0]      byte_next;

    assign q_rd = q_avail && (!valid_reg || pop);

    always_comb
    begin
        last_next = 1'b0;
        byte_next = '0;
        case (q_rec.kind)
            mhd_pkg::K_PAYLOAD:
            begin
                st_next   = mhd_pkg::ST_PAYLOAD;
                byte_next = q_rec.data;
            end
            mhd_pkg::K_LAST:
            begin
                st_next   = mhd_pkg::ST_PAYLOAD;
                byte_next = q_rec.data;
                last_next = 1'b1;
            end
            mhd_pkg::K_CSUM_DROP: st_next = mhd_pkg::ST_CSUM;
            mhd_pkg::K_OVERSIZE:  st_next = mhd_pkg::ST_OVERSIZE;
            mhd_pkg::K_EMPTY:     st_next = mhd_pkg::ST_EMPTY;
            default:              st_next = mhd_pkg::ST_CSUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            byte_reg   <= byte_next;
            proto_reg  <= q_rec.proto;
            last_reg   <= last_next;
            status_reg <= st_next;
        end
    end

    assign empty        = !valid_reg;
    assign payload_byte = byte_reg;
    assign protocol_id  = proto_reg;
    assign last         = last_reg;
    assign status       = status_reg;

endmodule

### src/marker_header_deframer.sv
// channel   direction  handshake            payload
// input     in         push / full          rx_byte[7:0]
// result    out        empty / pop          payload_byte, protocol_id, last, status
// config    in         cfg_valid/cfg_ready  max_payload[15:0]
//
// One input word per cycle while full is low; a result enters the queue at its
// accepting edge and moves from the queue head to the output register once that is free.
// full follows the result queue only: it rises when all FIFO_DEPTH entries hold words.
// Reset clears the parser to hunting, the queue and output to empty, max_payload to 1500.
// cfg_ready is always high; a stalled pop blocks input only once the queue fills.
module marker_header_deframer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  payload_byte,
    output logic [15:0] protocol_id,
    output logic        last,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_payload
);

    logic          in_take;
    logic          rec_we;
    mhd_pkg::rec_t rec;
    logic          q_rd;
    logic          q_avail;
    mhd_pkg::rec_t q_rec;

    assign cfg_ready = 1'b1;
    assign in_take   = push && !full;

    mhd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .in_byte  (rx_byte),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (max_payload),
        .rec_we   (rec_we),
        .rec      (rec)
    );

    mhd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (rec_we),
        .wr_rec (rec),
        .full   (full),
        .rd_en  (q_rd),
        .avail  (q_avail),
        .rd_rec (q_rec)
    );

    mhd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_avail),
        .q_rec        (q_rec),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .protocol_id  (protocol_id),
        .last         (last),
        .status       (status)
    );

endmodule
